FILE: sv/ffa_pkg.sv
`default_nettype none
package ffa_pkg;

  localparam int AW    = 10;         // address and length width
  localparam int ARENA = 1 << AW;    // granules in the arena
  localparam int SEGS  = 16;         // free segment table depth
  localparam int IW    = 4;          // segment index width
  localparam int CW    = 5;          // segment count width
  localparam int HDR   = 1;          // header granules

  localparam logic [AW-1:0] ARENA_RST = 10'd1023;

  typedef logic [AW-1:0] addr_t;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_RESET = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_NO_FIT     = 2'd1,
    ST_TABLE_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_NEXT,
    CELL_FROM_PREV
  } cell_op_t;

  typedef enum logic [2:0] {
    CH_NONE,
    CH_REBUILD,
    CH_WRITE,
    CH_DROP,
    CH_MERGE,
    CH_INSERT
  } chain_op_t;

  typedef struct packed {
    chain_op_t       op;
    logic [IW-1:0]   idx;
    addr_t           start;
    addr_t           len;
  } chain_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_FREE_RD,
    S_FREE_SEL,
    S_FREE_APPLY,
    S_MISC
  } fsm_t;

  // saturate a grown length to the largest arena length
  function automatic addr_t clamp_len(input logic [AW+1:0] v);
    addr_t r;
    if (v > {2'b00, {AW{1'b1}}}) begin
      r = {AW{1'b1}};
    end else begin
      r = v[AW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/ffa_cell.sv
`default_nettype none
module ffa_cell
  import ffa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cell_op_t op,
  input  wire addr_t    rst_start,
  input  wire addr_t    rst_len,
  input  wire addr_t    load_start,
  input  wire addr_t    load_len,
  input  wire addr_t    prev_start,
  input  wire addr_t    prev_len,
  input  wire addr_t    next_start,
  input  wire addr_t    next_len,
  output addr_t         start,
  output addr_t         len
);

  addr_t start_r;
  addr_t len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= rst_start;
      len_r   <= rst_len;
    end else begin
      unique case (op)
        CELL_HOLD: begin
          start_r <= start_r;
          len_r   <= len_r;
        end
        CELL_LOAD: begin
          start_r <= load_start;
          len_r   <= load_len;
        end
        CELL_FROM_NEXT: begin
          start_r <= next_start;
          len_r   <= next_len;
        end
        CELL_FROM_PREV: begin
          start_r <= prev_start;
          len_r   <= prev_len;
        end
        default: begin
          start_r <= start_r;
          len_r   <= len_r;
        end
      endcase
    end
  end

  assign start = start_r;
  assign len   = len_r;

endmodule
`default_nettype wire

FILE: sv/ffa_chain.sv
`default_nettype none
module ffa_chain
  import ffa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire chain_cmd_t cmd,
  input  wire addr_t      req_n,
  input  wire addr_t      hdr_addr,
  output addr_t           seg_start [SEGS],
  output addr_t           seg_len   [SEGS],
  output logic [CW-1:0]   count,
  output logic            fit_found,
  output logic [IW-1:0]   fit_idx,
  output logic [CW-1:0]   pos_k
);

  cell_op_t      op_a [SEGS];
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  // per-cell shift / load control
  always_comb begin
    for (int j = 0; j < SEGS; j++) begin
      op_a[j] = CELL_HOLD;
      unique case (cmd.op)
        CH_REBUILD: if (j == 0) op_a[j] = CELL_LOAD;
        CH_WRITE:   if (IW'(j) == cmd.idx) op_a[j] = CELL_LOAD;
        CH_DROP:    if (IW'(j) >= cmd.idx) op_a[j] = CELL_FROM_NEXT;
        CH_MERGE: begin
          if (IW'(j) == cmd.idx) op_a[j] = CELL_LOAD;
          else if (IW'(j) > cmd.idx) op_a[j] = CELL_FROM_NEXT;
        end
        CH_INSERT: begin
          if (IW'(j) == cmd.idx) op_a[j] = CELL_LOAD;
          else if (IW'(j) > cmd.idx) op_a[j] = CELL_FROM_PREV;
        end
        default: op_a[j] = CELL_HOLD;
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < SEGS; g++) begin : g_cell
      addr_t ps, pl, ns, nl;
      if (g == 0) begin : g_first
        assign ps = seg_start[g];
        assign pl = seg_len[g];
      end else begin : g_mid
        assign ps = seg_start[g-1];
        assign pl = seg_len[g-1];
      end
      if (g == SEGS - 1) begin : g_last
        assign ns = seg_start[g];
        assign nl = seg_len[g];
      end else begin : g_inner
        assign ns = seg_start[g+1];
        assign nl = seg_len[g+1];
      end
      ffa_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op_a[g]),
        .rst_start  ('0),
        .rst_len    ((g == 0) ? ARENA_RST : '0),
        .load_start (cmd.start),
        .load_len   (cmd.len),
        .prev_start (ps),
        .prev_len   (pl),
        .next_start (ns),
        .next_len   (nl),
        .start      (seg_start[g]),
        .len        (seg_len[g])
      );
    end
  endgenerate

  always_comb begin
    unique case (cmd.op)
      CH_REBUILD:       count_nxt = CW'(1);
      CH_DROP, CH_MERGE: count_nxt = count_r - CW'(1);
      CH_INSERT:        count_nxt = count_r + CW'(1);
      default:          count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CW'(1);
    end else begin
      count_r <= count_nxt;
    end
  end

  // first fitting segment, and first segment above the header address
  always_comb begin
    fit_found = 1'b0;
    fit_idx   = '0;
    pos_k     = count_r;
    for (int j = SEGS - 1; j >= 0; j--) begin
      if (CW'(j) < count_r && seg_len[j] >= req_n) begin
        fit_found = 1'b1;
        fit_idx   = IW'(j);
      end
      if (CW'(j) < count_r && seg_start[j] > hdr_addr) begin
        pos_k = CW'(j);
      end
    end
  end

  assign count = count_r;

endmodule
`default_nettype wire

FILE: sv/first_fit_free_list_allocator_top.sv
`default_nettype none
// channel  | handshake              | payload
// ---------+------------------------+----------------------------------------
// in_      | in_valid / in_stall    | in_req_type, in_req_size, in_block_addr
// out_     | out_valid / out_stall  | out_status, out_payload_addr
// cfg_     | cfg_wr_en              | cfg_wr_data (arena_size)
//
// one request at a time; every request gives one result transfer
// allocate, reset, other: result registered from the S_ALLOC or S_MISC state
// free: result registered from S_FREE_APPLY, after S_FREE_RD and S_FREE_SEL
// the free path needs S_FREE_RD for the header store's registered read and S_FREE_SEL for the neighbour lookup
// synchronous active-low reset restores one free segment of 1023 granules
// input is stalled while a request is in work or a result is valid on the output
module first_fit_free_list_allocator_top
  import ffa_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [1:0]    in_req_type,
  input  wire logic [AW-1:0] in_req_size,
  input  wire logic [AW-1:0] in_block_addr,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         out_status,
  output logic [AW-1:0]      out_payload_addr,
  input  wire logic          cfg_wr_en,
  input  wire logic [AW-1:0] cfg_wr_data
);

  fsm_t state_r, state_nxt;

  addr_t arena_r;
  logic [1:0] req_type_r;
  addr_t req_size_r;
  addr_t h_r;                 // header address of the block to free

  // neighbour snapshot taken in the select step
  logic [CW-1:0] k_r;
  logic has_prev_r, has_next_r;
  addr_t pstart_r, plen_r, nstart_r, nlen_r;

  logic out_valid_r;
  logic [1:0] out_status_r;
  addr_t out_addr_r;

  // header store of granted lengths, never cleared
  addr_t blk_mem [ARENA];
  addr_t mem_rdata_r;
  logic  mem_we;
  addr_t mem_waddr, mem_wdata;

  chain_cmd_t cmd;
  addr_t seg_start [SEGS];
  addr_t seg_len   [SEGS];
  logic [CW-1:0] count;
  logic fit_found;
  logic [IW-1:0] fit_idx;
  logic [CW-1:0] pos_k;

  logic res_load;
  logic [1:0] res_status;
  addr_t res_addr;

  logic in_xfer;

  // alloc datapath
  addr_t f_start, f_len;
  logic  split;

  // free datapath
  addr_t blk_len;
  logic  left, right;
  logic [IW-1:0] pidx;

  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign in_xfer  = in_valid && !in_stall;

  ffa_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .req_n     (req_size_r),
    .hdr_addr  (h_r),
    .seg_start (seg_start),
    .seg_len   (seg_len),
    .count     (count),
    .fit_found (fit_found),
    .fit_idx   (fit_idx),
    .pos_k     (pos_k)
  );

  assign f_start = seg_start[fit_idx];
  assign f_len   = seg_len[fit_idx];
  // split only when the remainder exceeds one header
  assign split   = {1'b0, f_len} > ({1'b0, req_size_r} + (AW+1)'(HDR));

  assign blk_len = mem_rdata_r;
  assign left  = has_prev_r &&
                 (({1'b0, pstart_r} + (AW+1)'(HDR) + {1'b0, plen_r}) == {1'b0, h_r});
  assign right = has_next_r &&
                 (({1'b0, h_r} + (AW+1)'(HDR) + {1'b0, blk_len}) == {1'b0, nstart_r});
  assign pidx  = IW'(pos_k - CW'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (req_t'(in_req_type))
            REQ_ALLOC: state_nxt = S_ALLOC;
            REQ_FREE:  state_nxt = S_FREE_RD;
            default:   state_nxt = S_MISC;
          endcase
        end
      end
      S_FREE_RD:    state_nxt = S_FREE_SEL;
      S_FREE_SEL:   state_nxt = S_FREE_APPLY;
      S_ALLOC, S_FREE_APPLY, S_MISC: state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  // chain commands, store writes and results
  always_comb begin
    cmd        = '{op: CH_NONE, idx: '0, start: '0, len: '0};
    mem_we     = 1'b0;
    mem_waddr  = f_start;
    mem_wdata  = f_len;
    res_load   = 1'b0;
    res_status = ST_DONE;
    res_addr   = '0;
    unique case (state_r)
      S_ALLOC: begin
        res_load = 1'b1;
        if (fit_found) begin
          mem_we   = 1'b1;
          res_addr = AW'(f_start + AW'(HDR));
          if (split) begin
            mem_wdata = req_size_r;
            cmd = '{op: CH_WRITE, idx: fit_idx,
                    start: AW'(f_start + AW'(HDR) + req_size_r),
                    len: AW'(f_len - req_size_r - AW'(HDR))};
          end else begin
            cmd = '{op: CH_DROP, idx: fit_idx, start: '0, len: '0};
          end
        end else begin
          res_status = ST_NO_FIT;
        end
      end
      S_FREE_APPLY: begin
        res_load = 1'b1;
        priority if (left && right) begin
          cmd = '{op: CH_MERGE, idx: IW'(k_r - CW'(1)), start: pstart_r,
                  len: clamp_len({2'b00, plen_r} + (AW+2)'(HDR) + {2'b00, blk_len}
                                 + (AW+2)'(HDR) + {2'b00, nlen_r})};
        end else if (left) begin
          cmd = '{op: CH_WRITE, idx: IW'(k_r - CW'(1)), start: pstart_r,
                  len: clamp_len({2'b00, plen_r} + (AW+2)'(HDR) + {2'b00, blk_len})};
        end else if (right) begin
          cmd = '{op: CH_WRITE, idx: k_r[IW-1:0], start: h_r,
                  len: clamp_len({2'b00, blk_len} + (AW+2)'(HDR) + {2'b00, nlen_r})};
        end else if (count >= CW'(SEGS)) begin
          res_status = ST_TABLE_FULL;
        end else begin
          cmd = '{op: CH_INSERT, idx: k_r[IW-1:0], start: h_r, len: blk_len};
        end
      end
      S_MISC: begin
        res_load = 1'b1;
        if (req_t'(req_type_r) == REQ_RESET) begin
          cmd = '{op: CH_REBUILD, idx: '0, start: '0, len: arena_r};
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      arena_r     <= ARENA_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        arena_r <= cfg_wr_data;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture, neighbour snapshot and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_type_r <= in_req_type;
      req_size_r <= in_req_size;
      h_r        <= AW'(in_block_addr - AW'(HDR));
    end
    if (state_r == S_FREE_SEL) begin
      k_r        <= pos_k;
      has_prev_r <= (pos_k != '0);
      has_next_r <= (pos_k < count);
      pstart_r   <= seg_start[pidx];
      plen_r     <= seg_len[pidx];
      nstart_r   <= seg_start[pos_k[IW-1:0]];
      nlen_r     <= seg_len[pos_k[IW-1:0]];
    end
    if (res_load) begin
      out_status_r <= res_status;
      out_addr_r   <= res_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      blk_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= blk_mem[h_r];
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_payload_addr = out_addr_r;

endmodule
`default_nettype wire
